@@ hdl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] key;
        logic [15:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [15:0] head_key;
        logic [15:0] head_payload;
        logic        is_empty;
        logic [4:0]  entry_count;
        logic        push_dropped;
    } t_out_item;

    // one stored entry as seen by a neighbor
    typedef struct packed {
        logic        valid;
        logic        place;   // valid key greater than incoming key, or free
        logic [15:0] key;
        logic [15:0] payload;
    } t_entry;

    // operation broadcast to every cell
    typedef struct packed {
        logic        push;
        logic        pop;
        logic [15:0] key;
        logic [15:0] payload;
    } t_cell_ctl;

    function automatic logic [4:0] count_field(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[4:0];
    endfunction

endpackage
`default_nettype wire

@@ hdl/spq_cell.sv @@
`default_nettype none
module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_prev,
    input  wire t_entry    i_next,
    output t_entry         o_self
);

    logic        r_valid;
    logic [15:0] r_key;
    logic [15:0] r_payload;
    logic        place;
    logic        take_prev;
    logic        take_new;

    // sorted order makes place monotonic along the chain
    assign place     = !r_valid || (r_key > i_ctl.key);
    assign take_prev = i_ctl.push && i_prev.place && i_prev.valid;
    assign take_new  = i_ctl.push && place && !i_prev.place;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.pop) begin
            r_valid <= i_next.valid;
        end else if (take_prev) begin
            r_valid <= 1'b1;
        end else if (take_new) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_key     <= i_next.key;
            r_payload <= i_next.payload;
        end else if (take_prev) begin
            r_key     <= i_prev.key;
            r_payload <= i_prev.payload;
        end else if (take_new) begin
            r_key     <= i_ctl.key;
            r_payload <= i_ctl.payload;
        end
    end

    assign o_self = '{valid: r_valid, place: place, key: r_key, payload: r_payload};

endmodule
`default_nettype wire

@@ hdl/sorted_priority_queue.sv @@
// Result: o_done is registered from the command transfer and rises in the cycle after it.
// Throughput: one command per cycle; start is taken every cycle, busy stays low,
// set by the compare-and-shift step of each cell in the chain.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset (synchronous, active low) empties the queue; entry contents are not cleared.
`default_nettype none
module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_item i_cmd,
    output logic          busy,
    output logic          o_done,
    output t_out_item     o_res
);

    t_entry      cells [DEPTH];
    t_entry      prev_in [DEPTH];
    t_entry      next_in [DEPTH];
    t_cell_ctl   ctl;
    logic        accept;
    logic        full;
    logic        r_done;
    logic        r_dropped;
    logic [CNT_W-1:0] r_count;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = cells[DEPTH-1].valid;

    always_comb begin
        ctl.push    = accept && (i_cmd.command == CMD_PUSH) && !full;
        ctl.pop     = accept && (i_cmd.command == CMD_POP);
        ctl.key     = i_cmd.key;
        ctl.payload = i_cmd.payload;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign prev_in[g] = '0;
        end else begin : g_mid
            assign prev_in[g] = cells[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign next_in[g] = '0;
        end else begin : g_body
            assign next_in[g] = cells[g+1];
        end

        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_prev  (prev_in[g]),
            .i_next  (next_in[g]),
            .o_self  (cells[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= 1'b0;
            r_dropped <= 1'b0;
            r_count   <= '0;
        end else begin
            r_done    <= accept;
            r_dropped <= accept && (i_cmd.command == CMD_PUSH) && full;
            if (ctl.push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (ctl.pop && (r_count != '0)) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // head cell already holds the state after the last transfer
    always_comb begin
        o_res.head_key     = cells[0].valid ? cells[0].key : 16'd0;
        o_res.head_payload = cells[0].valid ? cells[0].payload : 16'd0;
        o_res.is_empty     = !cells[0].valid;
        o_res.entry_count  = count_field(r_count);
        o_res.push_dropped = r_dropped;
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

@@ hdl/spq_checker.sv @@
`default_nettype none
module spq_checker
    import spq_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire t_in_item  i_cmd,
    input wire logic      busy,
    input wire logic      o_done,
    input wire t_out_item o_res
);

    // every result follows a command transfer in the previous cycle
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_done |-> $past(start && !busy))
        else $error("result without command");

    // a dropped push only follows a push and leaves the queue full
    a_drop_on_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.push_dropped |->
            $past(i_cmd.command == CMD_PUSH) && !o_res.is_empty
            && (32'(o_res.entry_count) == (DEPTH % 32)))
        else $error("push dropped while not full");

    // empty flag matches a zero head and a zero entry count
    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.is_empty |->
            (o_res.head_key == 16'd0) && (o_res.head_payload == 16'd0)
            && (o_res.entry_count == 5'd0))
        else $error("empty result with data");

    // a pop never reports a drop
    a_pop_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.command == CMD_POP) |=> !o_res.push_dropped)
        else $error("pop flagged as dropped push");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_cmd   (i_cmd),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
`default_nettype wire

@@ tb/tb_sorted_priority_queue.sv @@
`default_nettype none
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int N_RANDOM   = 800;
    localparam int DOG_LIMIT  = 2000;
    localparam int N_DIRECTED = 25;

    // directed row: command, and a typed-in result where one is given
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item res;
    } t_row;

    localparam t_out_item EMPTY_RES = '{16'h0000, 16'h0000, 1'b1, 5'd0, 1'b0};
    localparam t_out_item NO_RES    = '0;

    localparam t_row DIR_TAB [N_DIRECTED] = '{
        '{'{CMD_POP,  16'h0000, 16'h0000}, 1'b1, EMPTY_RES},
        '{'{CMD_PUSH, 16'hFFFF, 16'h0000}, 1'b1, '{16'hFFFF, 16'h0000, 1'b0, 5'd1, 1'b0}},
        '{'{CMD_PUSH, 16'h0000, 16'hFFFF}, 1'b1, '{16'h0000, 16'hFFFF, 1'b0, 5'd2, 1'b0}},
        // equal key goes behind the one already stored
        '{'{CMD_PUSH, 16'h0000, 16'h1234}, 1'b1, '{16'h0000, 16'hFFFF, 1'b0, 5'd3, 1'b0}},
        '{'{CMD_POP,  16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, 16'h1234, 1'b0, 5'd2, 1'b0}},
        '{'{CMD_POP,  16'h0000, 16'h0000}, 1'b1, '{16'hFFFF, 16'h0000, 1'b0, 5'd1, 1'b0}},
        '{'{CMD_POP,  16'h0000, 16'h0000}, 1'b1, EMPTY_RES},
        '{'{CMD_POP,  16'h5A5A, 16'hA5A5}, 1'b1, EMPTY_RES},
        // fill to capacity with ties mixed in
        '{'{CMD_PUSH, 16'h8000, 16'h0101}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h0001, 16'h0202}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h7FFF, 16'h0303}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h0001, 16'h0404}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'hAAAA, 16'h0505}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h5555, 16'h0606}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h0001, 16'h0707}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'hFFFF, 16'h0808}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h0000, 16'h0909}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'hFFFE, 16'h0A0A}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h1000, 16'h0B0B}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h0100, 16'h0C0C}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h0010, 16'h0D0D}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h8000, 16'h0E0E}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'h4000, 16'h0F0F}, 1'b0, NO_RES},
        '{'{CMD_PUSH, 16'hC000, 16'h1010}, 1'b0, NO_RES},
        // full: this one is dropped
        '{'{CMD_PUSH, 16'h0000, 16'hBEEF}, 1'b0, NO_RES}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_cmd;
    logic      busy;
    logic      o_done;
    t_out_item o_res;

    // shadow copy of the queue, ascending keys, head at 0
    logic [15:0] held_key [DEPTH];
    logic [15:0] held_pay [DEPTH];
    int          held_count;

    t_out_item   head_reports [$];
    int          err_count;
    int          dog_count;

    sorted_priority_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic queue_apply(input t_in_item it, output t_out_item r);
        int pos;
        r = '0;
        if (it.command == CMD_PUSH) begin
            if (held_count >= DEPTH) begin
                r.push_dropped = 1'b1;
            end else begin
                pos = 0;
                while (pos < held_count && held_key[pos] <= it.key)
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_key[i] = held_key[i-1];
                    held_pay[i] = held_pay[i-1];
                end
                held_key[pos] = it.key;
                held_pay[pos] = it.payload;
                held_count++;
            end
        end else if (held_count > 0) begin
            for (int i = 0; i + 1 < held_count; i++) begin
                held_key[i] = held_key[i+1];
                held_pay[i] = held_pay[i+1];
            end
            held_count--;
        end
        if (held_count > 0) begin
            r.head_key     = held_key[0];
            r.head_payload = held_pay[0];
        end else begin
            r.is_empty = 1'b1;
        end
        r.entry_count = 5'(held_count);
    endtask

    // one command transfer; typed result overrides the prediction when given
    task automatic send_cmd(input t_in_item it, input bit may_idle,
                            input bit typed, input t_out_item typed_res);
        t_out_item r;
        while (may_idle && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= it;
        do @(posedge i_clk); while (busy);
        queue_apply(it, r);
        head_reports.push_back(typed ? typed_res : r);
    endtask

    function automatic t_in_item random_cmd(input int push_pct);
        t_in_item it;
        int       mode;
        it.command = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            it.key = 16'($urandom_range(0, 7));        // dense keys force ties
        else if (mode == 4)
            it.key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            it.key = 16'($urandom);
        it.payload = 16'($urandom);
        return it;
    endfunction

    task automatic mismatch(input string field, input int got, input int want);
        $display("[%0t] %s: got %0h, want %0h", $realtime, field, got, want);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (head_reports.size() == 0) begin
                mismatch("unexpected result", int'(o_res.head_key), 0);
            end else begin
                want = head_reports.pop_front();
                if (o_res.head_key != want.head_key)
                    mismatch("head_key", int'(o_res.head_key), int'(want.head_key));
                if (o_res.head_payload != want.head_payload)
                    mismatch("head_payload", int'(o_res.head_payload),
                             int'(want.head_payload));
                if (o_res.is_empty != want.is_empty)
                    mismatch("is_empty", int'(o_res.is_empty), int'(want.is_empty));
                if (o_res.entry_count != want.entry_count)
                    mismatch("entry_count", int'(o_res.entry_count),
                             int'(want.entry_count));
                if (o_res.push_dropped != want.push_dropped)
                    mismatch("push_dropped", int'(o_res.push_dropped),
                             int'(want.push_dropped));
            end
        end
    end

    // watchdog: cycles with no transfer in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            dog_count <= 0;
        else
            dog_count <= dog_count + 1;
        if (dog_count >= DOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int push_pct;
        err_count  = 0;
        dog_count  = 0;
        held_count = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++)
            send_cmd(DIR_TAB[n].item, 1'b1, DIR_TAB[n].typed, DIR_TAB[n].res);

        push_pct = 50;
        for (int n = 0; n < N_RANDOM; n++) begin
            // bursts lean toward filling or draining so both ends get hit
            if (n % 40 == 0) begin
                case ($urandom_range(0, 4))
                    0: push_pct = 10;
                    1: push_pct = 30;
                    2: push_pct = 50;
                    3: push_pct = 75;
                    default: push_pct = 90;
                endcase
            end
            if (n == 400) begin
                start <= 1'b0;
                while (head_reports.size() != 0) @(posedge i_clk);
            end
            send_cmd(random_cmd(push_pct), !(n >= 200 && n < 400), 1'b0, NO_RES);
        end
        start <= 1'b0;

        while (head_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
tb/tb_sorted_priority_queue.sv
